FILE: sv/ciss_pkg.sv
// Shared types, constants and helpers for the case-insensitive substring search.
package ciss_pkg;

    // Needle capacity and position counter width
    localparam int MAX_NEEDLE = 16;
    localparam int POS_BITS   = 16;
    localparam int LEN_BITS   = $clog2(MAX_NEEDLE + 1);
    localparam int MATCH_W    = 16;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // Action codes
    localparam logic [1:0] ACT_BEGIN  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_TEXT   = 2'd2;

    // Case folding constants
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] symbol;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [MATCH_W-1:0] match_start;
        logic               needle_overflow;
        logic               last_out;
    } t_out_item;

    // Per-cell control from the top level
    typedef struct packed {
        logic load;    // store the symbol as this cell's needle byte
        logic clear;   // drop the partial-match bit
        logic shift;   // take a new partial-match bit
        logic active;  // cell index is below the needle length
        logic tail;    // cell holds the last needle byte
    } t_cell_ctl;

    // Fold ASCII upper case to lower case
    function automatic logic [7:0] fold(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

FILE: sv/ciss_cell.sv
// One needle cell: holds a needle byte and one partial-match bit.
module ciss_cell
    import ciss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic [7:0] i_symbol,
    input  logic      i_prev,
    output logic      o_pm,
    output logic      o_hit
);

    logic [7:0] r_char;
    logic       r_pm;
    logic       n_pm;

    // Extend the neighbor's partial match by this byte
    assign n_pm  = i_prev & i_ctl.active & (r_char == i_symbol);
    assign o_hit = n_pm & i_ctl.tail;
    assign o_pm  = r_pm;

    // Hold the needle byte
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_char <= i_symbol;
        end
    end

    // Advance the partial-match bit; a shift already sees a masked neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm <= 1'b0;
        end else begin
            if (i_ctl.shift) begin
                r_pm <= n_pm;
            end else if (i_ctl.clear) begin
                r_pm <= 1'b0;
            end
        end
    end

endmodule

FILE: sv/case_insensitive_substring_search.sv
// Case-insensitive substring search: needle cell chain, match tracking, output skid.
//
// Input channel (i_in_valid / o_in_ready, payload i_in_data): action BEGIN
// clears the needle and match state, APPEND adds one needle byte (dropped and
// flagged once the 16-byte needle is full), TEXT streams one text byte. Code 3
// is ignored. Output channel (o_out_valid / i_out_ready, payload o_out_data)
// carries exactly one result per TEXT transfer and nothing for other actions.
// Each result is registered before it reaches o_out_valid. The block takes
// one item per cycle while o_in_ready is high: every needle cell compares its
// byte against the folded text byte and extends its neighbor's partial match
// in that same cycle. A text byte marked last ends the text; the next text
// byte restarts the text with the same needle.
// Reset empties the needle, clears all match state and empties the output.
// When the receiver stalls, one result waits in the output register and a
// second in a skid register; o_in_ready drops only while the skid is full.
module case_insensitive_substring_search
    import ciss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic                r_out_valid;
    t_out_item           r_out;
    logic                r_skid_valid;
    t_out_item           r_skid;

    logic [LEN_BITS-1:0] r_len;
    logic                r_overflow;
    logic [POS_BITS-1:0] r_pos;
    logic                r_seen;
    logic [POS_BITS-1:0] r_start;
    logic                r_ended;

    logic [LEN_BITS-1:0] n_len;
    logic                n_overflow;
    logic [POS_BITS-1:0] n_pos;
    logic                n_seen;
    logic [POS_BITS-1:0] n_start;
    logic                n_ended;

    logic                w_accept;
    logic                w_begin;
    logic                w_append;
    logic                w_text;
    logic                w_push;
    logic                w_pop;
    logic [7:0]          w_sym;
    logic                w_eff_seen;
    logic [POS_BITS-1:0] w_eff_pos;
    logic                w_update;
    logic                w_clear;
    logic [MAX_NEEDLE-1:0] w_pm;
    logic [MAX_NEEDLE-1:0] w_hit;
    logic [POS_BITS+MATCH_W-1:0] w_start_ext;
    t_out_item           w_result;

    // Decode the input transfer
    assign o_in_ready = ~r_skid_valid;
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_begin    = w_accept && (i_in_data.action == ACT_BEGIN);
    assign w_append   = w_accept && (i_in_data.action == ACT_APPEND);
    assign w_text     = w_accept && (i_in_data.action == ACT_TEXT);
    assign w_sym      = fold(i_in_data.symbol);

    // A finished text restarts on its next byte
    assign w_eff_seen = r_seen & ~r_ended;
    assign w_eff_pos  = r_ended ? '0 : r_pos;
    assign w_update   = w_text & ~w_eff_seen & (r_len != '0);
    assign w_clear    = w_begin | w_append | (w_text & r_ended);

    // Needle cell chain
    for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
        t_cell_ctl w_ctl;
        logic      w_prev;

        assign w_ctl.load   = w_append && (r_len == LEN_BITS'(k));
        assign w_ctl.clear  = w_clear;
        assign w_ctl.shift  = w_update;
        assign w_ctl.active = LEN_BITS'(k) < r_len;
        assign w_ctl.tail   = r_len == LEN_BITS'(k + 1);

        if (k == 0) begin : g_head
            assign w_prev = 1'b1;
        end else begin : g_link
            assign w_prev = w_pm[k-1] & ~r_ended;
        end

        ciss_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_symbol (w_sym),
            .i_prev   (w_prev),
            .o_pm     (w_pm[k]),
            .o_hit    (w_hit[k])
        );
    end

    // Next needle and text state
    always_comb begin
        n_len      = r_len;
        n_overflow = r_overflow;
        n_pos      = r_pos;
        n_seen     = r_seen;
        n_start    = r_start;
        n_ended    = r_ended;
        if (w_begin || w_append) begin
            n_pos   = '0;
            n_seen  = 1'b0;
            n_start = '0;
            n_ended = 1'b0;
        end
        if (w_begin) begin
            n_len      = '0;
            n_overflow = 1'b0;
        end
        if (w_append) begin
            if (r_len < LEN_BITS'(MAX_NEEDLE)) begin
                n_len = r_len + 1'b1;
            end else begin
                n_overflow = 1'b1;
            end
        end
        if (w_text) begin
            n_seen  = w_eff_seen;
            n_start = r_ended ? '0 : r_start;
            if (!w_eff_seen) begin
                if (r_len == '0) begin
                    n_seen  = 1'b1;
                    n_start = w_eff_pos;
                end else if (|w_hit) begin
                    n_seen  = 1'b1;
                    n_start = w_eff_pos - POS_BITS'(r_len) + 1'b1;
                end
            end
            n_pos   = (w_eff_pos == POS_MAX) ? w_eff_pos : w_eff_pos + 1'b1;
            n_ended = i_in_data.last;
        end
    end

    // Form the result from the updated state
    assign w_start_ext = {MATCH_W'(0), n_start};
    always_comb begin
        w_result.found           = n_seen;
        w_result.match_start     = n_seen ? w_start_ext[MATCH_W-1:0] : '0;
        w_result.needle_overflow = n_overflow;
        w_result.last_out        = i_in_data.last;
    end

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_overflow <= 1'b0;
            r_pos      <= '0;
            r_seen     <= 1'b0;
            r_start    <= '0;
            r_ended    <= 1'b0;
        end else if (w_accept) begin
            r_len      <= n_len;
            r_overflow <= n_overflow;
            r_pos      <= n_pos;
            r_seen     <= n_seen;
            r_start    <= n_start;
            r_ended    <= n_ended;
        end
    end

    // Output register with skid
    assign w_push = w_text;
    assign w_pop  = r_out_valid & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_push) begin
                r_out <= w_result;
            end
        end else if (w_push) begin
            r_skid <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_BITS'(MAX_NEEDLE))
        else $error("needle length beyond capacity");

    a_pm_in_needle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pm >> r_len) == '0)
        else $error("partial match bit set beyond needle length");

    a_begin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_begin |=> (r_len == '0) && !r_overflow && !r_seen && (w_pm == '0))
        else $error("begin did not clear the search state");

    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |-> (o_out_data.match_start == '0))
        else $error("match start nonzero without a match");
`endif

endmodule

FILE: tb/case_insensitive_substring_search_test.sv
// Testbench for the case-insensitive substring search: directed and random searches vs. a local model.
module case_insensitive_substring_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ciss_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int TAIL_CYCLES  = 8;
    localparam int RANDOM_ITEMS = 440;
    localparam int REPORT_LIMIT = 10;

    // Action code 3 has no meaning; the block must ignore it
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Receiver ready pattern, one bit per cycle
    localparam logic [10:0] RX_PATTERN_BITS = 11'b10110111001;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_STARVED} t_rx_mode;

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data  = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    // Search model state
    logic [7:0]            needle_bytes [MAX_NEEDLE];
    int unsigned           needle_len = 0;
    logic [MAX_NEEDLE-1:0] partial_hits = '0;
    logic [POS_BITS-1:0]   text_pos = '0;
    bit                    match_found = 1'b0;
    logic [POS_BITS-1:0]   match_pos = '0;
    bit                    needle_dropped = 1'b0;
    bit                    text_closed = 1'b0;
    t_out_item             pending_results [$];

    // Run statistics
    int errors           = 0;
    int items_sent       = 0;
    int results_checked  = 0;
    int matches_reported = 0;
    int overflow_reports = 0;
    int in_stall_cycles  = 0;
    int cycle_count      = 0;

    // Sender pacing
    bit gaps_on    = 1'b0;
    int gap_max    = 3;
    int burst_left = 4;

    // Receiver pacing
    t_rx_mode rx_mode       = RX_ALWAYS;
    int       hold_requests = 0;
    int       holds_served  = 0;
    int       hold_left     = 0;
    int       rx_phase      = 0;

    case_insensitive_substring_search uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Only A..Z move; everything else compares as is
    function automatic logic [7:0] lower_case(input logic [7:0] b);
        return (b inside {[8'h41:8'h5A]}) ? (b | 8'h20) : b;
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] b);
        if ((b inside {[8'h41:8'h5A], [8'h61:8'h7A]}) && $urandom_range(0, 1)) begin
            return b ^ 8'h20;
        end
        return b;
    endfunction

    // Small alphabet so partial matches overlap often, plus '@' and '`' that must not fold
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0: b = 8'($urandom_range(0, 255));
            1: b = 8'h40;
            2: b = 8'h60;
            default: b = 8'h61 + 8'($urandom_range(0, 2));
        endcase
        return flip_case(b);
    endfunction

    function automatic void restart_text();
        partial_hits = '0;
        text_pos     = '0;
        match_found  = 1'b0;
        match_pos    = '0;
        text_closed  = 1'b0;
    endfunction

    // Advance the model by one transfer; a text byte queues one result
    function automatic void predict_step(input t_in_item item);
        logic [7:0]            sym;
        logic [MAX_NEEDLE-1:0] eq;
        logic [POS_BITS-1:0]   idx;
        t_out_item             res;
        sym = lower_case(item.symbol);
        case (item.action)
            ACT_BEGIN: begin
                needle_len     = 0;
                needle_dropped = 1'b0;
                restart_text();
            end
            ACT_APPEND: begin
                if (needle_len < MAX_NEEDLE) begin
                    needle_bytes[needle_len] = sym;
                    needle_len++;
                end else begin
                    needle_dropped = 1'b1;
                end
                restart_text();
            end
            ACT_TEXT: begin
                if (text_closed) begin
                    restart_text();
                end
                idx = text_pos;
                if (!match_found) begin
                    if (needle_len == 0) begin
                        match_found = 1'b1;
                        match_pos   = idx;
                    end else begin
                        eq = '0;
                        for (int k = 0; k < needle_len; k++) begin
                            eq[k] = (needle_bytes[k] == sym);
                        end
                        partial_hits = {partial_hits[MAX_NEEDLE-2:0], 1'b1} & eq;
                        if (partial_hits[needle_len-1]) begin
                            match_found = 1'b1;
                            match_pos   = idx - POS_BITS'(needle_len - 1);
                        end
                    end
                end
                if (text_pos != POS_MAX) begin
                    text_pos++;
                end
                text_closed         = item.last;
                res.found           = match_found;
                res.match_start     = match_found ? MATCH_W'(match_pos) : '0;
                res.needle_overflow = needle_dropped;
                res.last_out        = item.last;
                pending_results.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic void note_error(input string what);
        errors++;
        if (errors <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endfunction

    function automatic void check_result(input t_out_item want, input t_out_item got);
        if (got.found !== want.found) begin
            note_error($sformatf("found expected %0b got %0b", want.found, got.found));
        end
        if (got.match_start !== want.match_start) begin
            note_error($sformatf("match_start expected %0d got %0d",
                                 want.match_start, got.match_start));
        end
        if (got.needle_overflow !== want.needle_overflow) begin
            note_error($sformatf("needle_overflow expected %0b got %0b",
                                 want.needle_overflow, got.needle_overflow));
        end
        if (got.last_out !== want.last_out) begin
            note_error($sformatf("last_out expected %0b got %0b", want.last_out, got.last_out));
        end
        if (want.found) matches_reported++;
        if (want.needle_overflow) overflow_reports++;
    endfunction

    // Check each result transfer against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                note_error($sformatf("result with nothing expected: found=%0b start=%0d last=%0b",
                                     out_data.found, out_data.match_start, out_data.last_out));
            end else begin
                check_result(pending_results.pop_front(), out_data);
            end
        end
    end

    // Drive ready from the current mode; a hold request forces a long stall
    always @(posedge clk) begin
        if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        rx_phase++;
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  out_ready <= 1'b1;
                RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: out_ready <= RX_PATTERN_BITS[rx_phase % 11];
                default:    out_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one item, hold it until the transfer, then maybe close the burst
    task automatic send_item(input logic [1:0] act, input logic [7:0] sym, input logic is_last);
        t_in_item item;
        item.action = act;
        item.symbol = sym;
        item.last   = is_last;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) begin
            in_stall_cycles++;
            @(posedge clk);
        end
        predict_step(item);
        if (act != ACT_UNUSED) items_sent++;
        if (gaps_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
                burst_left = $urandom_range(1, 10);
            end
        end
    endtask

    // Drop valid and wait until every predicted result has arrived
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic begin_search();
        send_item(ACT_BEGIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_needle(input string s);
        foreach (s[i]) send_item(ACT_APPEND, s[i], 1'b0);
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++) begin
            send_item(ACT_TEXT, s[i], close && (i == s.len() - 1));
        end
    endtask

    // Empty needle matches at once, empty text yields nothing, code 3 is ignored
    task automatic test_empty_cases();
        rx_mode = RX_RANDOM;
        gaps_on = 1'b1;
        begin_search();
        send_item(ACT_TEXT, 8'h00, 1'b0);
        send_item(ACT_TEXT, 8'hFF, 1'b1);
        begin_search();
        send_needle("x");
        begin_search();
        send_needle("x");
        send_item(ACT_UNUSED, "x", 1'b1);
        send_text("X", 1'b1);
        wait_for_drain();
    endtask

    // Fold edges: A and Z fold, '@' and '[' next to them do not
    task automatic test_case_folding();
        rx_mode = RX_PATTERN;
        begin_search();
        send_needle("Z@");
        send_text("z`z@", 1'b1);
        begin_search();
        send_needle("[a");
        send_text("{A[A", 1'b1);
        wait_for_drain();
    endtask

    // A needle byte mid-text restarts the text; a byte after last starts a new text
    task automatic test_restart_rules();
        rx_mode = RX_RANDOM;
        begin_search();
        send_needle("ab");
        send_text("xa", 1'b0);
        send_needle("B");
        send_text("abb", 1'b1);
        send_text("qabB", 1'b1);
        wait_for_drain();
    endtask

    // Seventeen needle bytes: the last is dropped and flagged
    task automatic test_needle_overflow();
        rx_mode = RX_ALWAYS;
        begin_search();
        send_needle("aaaaaaaaaaaaaaaaa");
        send_text("A", 1'b1);
        send_text("aaaaaaaaaaaaaaaA", 1'b1);
        wait_for_drain();
    endtask

    // Long receiver hold while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        gaps_on = 1'b0;
        rx_mode = RX_RANDOM;
        begin_search();
        send_needle("ca");
        hold_requests++;
        for (int i = 0; i < 40; i++) begin
            send_item(ACT_TEXT, pick_byte(), i == 39);
        end
        wait_for_drain();
    endtask

    // Mostly well-formed searches with random content, some noise and broken sequences
    task automatic test_random_searches(input int count);
        int         goal;
        int         nlen;
        int         kept;
        int         tlen;
        int         at;
        int         cut;
        bit         plant;
        bit         abandon;
        logic [7:0] needle [$];
        logic [7:0] text [$];
        goal    = items_sent + count;
        rx_mode = RX_RANDOM;
        gaps_on = 1'b1;
        while (items_sent < goal) begin
            // Change pacing now and then, including stretches with none
            if ($urandom_range(0, 5) == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                gaps_on = ($urandom_range(0, 2) != 0);
                gap_max = $urandom_range(1, 6);
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                end
                continue;
            end
            case ($urandom_range(0, 9))
                0: nlen = 0;
                1: nlen = $urandom_range(MAX_NEEDLE - 1, MAX_NEEDLE + 2);
                default: nlen = $urandom_range(1, 5);
            endcase
            kept = (nlen < MAX_NEEDLE) ? nlen : MAX_NEEDLE;
            needle.delete();
            repeat (nlen) needle.push_back(pick_byte());
            begin_search();
            foreach (needle[i]) send_item(ACT_APPEND, needle[i], 1'b0);
            abandon = 1'b0;
            repeat ($urandom_range(1, 3)) begin
                if (abandon) break;
                plant = (kept > 0) && $urandom_range(0, 1);
                tlen  = plant ? $urandom_range(kept, kept + 12) : $urandom_range(1, 20);
                text.delete();
                repeat (tlen) text.push_back(pick_byte());
                if (plant) begin
                    at = $urandom_range(0, tlen - kept);
                    for (int i = 0; i < kept; i++) text[at + i] = flip_case(needle[i]);
                end
                // Occasionally cut the text short with a new needle byte or a new search
                cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, tlen - 1) : tlen;
                for (int i = 0; i < tlen; i++) begin
                    if (i == cut) begin
                        send_item($urandom_range(0, 1) ? ACT_APPEND : ACT_BEGIN,
                                  pick_byte(), 1'($urandom_range(0, 1)));
                        abandon = 1'b1;
                        break;
                    end
                    send_item(ACT_TEXT, text[i],
                              (i == tlen - 1) && ($urandom_range(0, 7) != 0));
                end
            end
        end
        wait_for_drain();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_cases();
        test_case_folding();
        test_restart_rules();
        test_needle_overflow();
        test_backpressure();
        test_random_searches(RANDOM_ITEMS);

        // Let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0) begin
            note_error($sformatf("%0d expected results never arrived", pending_results.size()));
        end
        $display("Sent %0d transfers, checked %0d results (%0d with a match, %0d flagging overflow)",
                 items_sent, results_checked, matches_reported, overflow_reports);
        $display("Input stalled by the block for %0d cycles, %0d long receiver holds, %0d cycles run",
                 in_stall_cycles, holds_served, cycle_count);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/ciss_pkg.sv
sv/ciss_cell.sv
sv/case_insensitive_substring_search.sv
tb/case_insensitive_substring_search_test.sv
